[rtl/bdhm_pkg.sv]
package bdhm_pkg;

   // Fixed-point precision of the HSV reciprocals.
   localparam int unsigned HSV_SHIFT   = 12;
   localparam int unsigned SAT_SCALE   = 255;
   localparam int unsigned HUE_RANGE   = 180;
   localparam int unsigned HUE_SECTORS = 6;

   localparam int unsigned CHAN_W      = 8;
   localparam int unsigned HUE_NUM_W   = 12;
   localparam int unsigned SAT_RECIP_W = 20;
   localparam int unsigned HUE_RECIP_W = 17;
   localparam int unsigned SAT_PROD_W  = CHAN_W + SAT_RECIP_W;
   localparam int unsigned HUE_PROD_W  = HUE_NUM_W + HUE_RECIP_W + 1;
   localparam int unsigned HUE_RAW_W   = 9;
   localparam int unsigned CSR_INDEX_W = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GREEN_HUE_LOW  = 3'd0,
      CSR_GREEN_HUE_HIGH = 3'd1,
      CSR_GREEN_SAT_LOW  = 3'd2,
      CSR_GREEN_VAL_LOW  = 3'd3,
      CSR_BROAD_SAT_HIGH = 3'd4,
      CSR_BROAD_VAL_LOW  = 3'd5
   } csr_index_type;

   localparam logic [CHAN_W-1:0] RST_GREEN_HUE_LOW  = 8'd39;
   localparam logic [CHAN_W-1:0] RST_GREEN_HUE_HIGH = 8'd114;
   localparam logic [CHAN_W-1:0] RST_GREEN_SAT_LOW  = 8'd58;
   localparam logic [CHAN_W-1:0] RST_GREEN_VAL_LOW  = 8'd81;
   localparam logic [CHAN_W-1:0] RST_BROAD_SAT_HIGH = 8'd235;
   localparam logic [CHAN_W-1:0] RST_BROAD_VAL_LOW  = 8'd60;

   typedef struct packed {
      logic [CHAN_W-1:0] green_hue_low;
      logic [CHAN_W-1:0] green_hue_high;
      logic [CHAN_W-1:0] green_sat_low;
      logic [CHAN_W-1:0] green_val_low;
      logic [CHAN_W-1:0] broad_sat_high;
      logic [CHAN_W-1:0] broad_val_low;
   } cfg_type;

   typedef struct packed {
      logic [CHAN_W-1:0] cur_blue;
      logic [CHAN_W-1:0] cur_green;
      logic [CHAN_W-1:0] cur_red;
      logic [CHAN_W-1:0] bg_blue;
      logic [CHAN_W-1:0] bg_green;
      logic [CHAN_W-1:0] bg_red;
   } pixel_type;

   typedef struct packed {
      logic [CHAN_W-1:0]           val;
      logic [CHAN_W-1:0]           diff;
      logic signed [HUE_NUM_W-1:0] hue_num;
   } diff_type;

   typedef struct packed {
      logic [CHAN_W-1:0]           val;
      logic [CHAN_W-1:0]           diff;
      logic signed [HUE_NUM_W-1:0] hue_num;
      logic [SAT_RECIP_W-1:0]      sat_recip;
      logic [HUE_RECIP_W-1:0]      hue_recip;
   } recip_type;

   typedef struct packed {
      logic [CHAN_W-1:0]            val;
      logic [SAT_PROD_W-1:0]        sat_prod;
      logic signed [HUE_PROD_W-1:0] hue_prod;
   } prod_type;

endpackage

[rtl/bdhm_diff_cell.sv]
module bdhm_diff_cell import bdhm_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  pixel_type in_data,
   output logic      out_valid,
   input  logic      out_ready,
   output diff_type  out_data
);

   logic              valid_ff;
   diff_type          data_ff;
   diff_type          data_in;
   logic [CHAN_W-1:0] b, g, r, vmax, vmin, diff;
   logic signed [HUE_NUM_W-1:0] b_s, g_s, r_s, diff_s;

   always_comb begin
      b = (in_data.cur_blue > in_data.bg_blue) ? in_data.cur_blue - in_data.bg_blue
                                               : in_data.bg_blue - in_data.cur_blue;
      g = (in_data.cur_green > in_data.bg_green) ? in_data.cur_green - in_data.bg_green
                                                 : in_data.bg_green - in_data.cur_green;
      r = (in_data.cur_red > in_data.bg_red) ? in_data.cur_red - in_data.bg_red
                                             : in_data.bg_red - in_data.cur_red;
      vmax = b;
      if (g > vmax) vmax = g;
      if (r > vmax) vmax = r;
      vmin = b;
      if (g < vmin) vmin = g;
      if (r < vmin) vmin = r;
      diff = vmax - vmin;

      b_s    = $signed({4'b0, b});
      g_s    = $signed({4'b0, g});
      r_s    = $signed({4'b0, r});
      diff_s = $signed({4'b0, diff});

      data_in.val  = vmax;
      data_in.diff = diff;
      // Ties on the maximum go to red first, then green.
      if (vmax == r) begin
         data_in.hue_num = g_s - b_s;
      end else if (vmax == g) begin
         data_in.hue_num = b_s - r_s + (diff_s <<< 1);
      end else begin
         data_in.hue_num = r_s - g_s + (diff_s <<< 2);
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

[rtl/bdhm_recip_cell.sv]
module bdhm_recip_cell import bdhm_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  diff_type  in_data,
   output logic      out_valid,
   input  logic      out_ready,
   output recip_type out_data
);

   localparam int unsigned TableDepth = 1 << CHAN_W;

   logic [SAT_RECIP_W-1:0] sat_table [TableDepth];
   logic [HUE_RECIP_W-1:0] hue_table [TableDepth];
   logic                   valid_ff;
   recip_type              data_ff;
   recip_type              data_in;

   // Rounded reciprocals: 255/v for saturation and 180/(6*diff) for hue.
   // A zero divisor gives a zero entry.
   for (genvar i = 0; i < TableDepth; i++) begin : g_table
      localparam int unsigned SatDen = (i == 0) ? 2 : 2 * i;
      localparam int unsigned SatVal =
         (i == 0) ? 0 : (2 * (SAT_SCALE << HSV_SHIFT) + i) / SatDen;
      localparam int unsigned HueDen = (i == 0) ? 2 : 2 * HUE_SECTORS * i;
      localparam int unsigned HueVal =
         (i == 0) ? 0 : (2 * (HUE_RANGE << HSV_SHIFT) + HUE_SECTORS * i) / HueDen;
      assign sat_table[i] = SAT_RECIP_W'(SatVal);
      assign hue_table[i] = HUE_RECIP_W'(HueVal);
   end

   always_comb begin
      data_in.val       = in_data.val;
      data_in.diff      = in_data.diff;
      data_in.hue_num   = in_data.hue_num;
      data_in.sat_recip = sat_table[in_data.val];
      data_in.hue_recip = hue_table[in_data.diff];
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

[rtl/bdhm_mult_cell.sv]
module bdhm_mult_cell import bdhm_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  recip_type in_data,
   output logic      out_valid,
   input  logic      out_ready,
   output prod_type  out_data
);

   logic     valid_ff;
   prod_type data_ff;
   prod_type data_in;

   always_comb begin
      data_in.val      = in_data.val;
      data_in.sat_prod = SAT_PROD_W'(in_data.diff) * SAT_PROD_W'(in_data.sat_recip);
      data_in.hue_prod = HUE_PROD_W'(in_data.hue_num) *
                         $signed({{(HUE_PROD_W - HUE_RECIP_W){1'b0}}, in_data.hue_recip});
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

[rtl/bdhm_mask_cell.sv]
module bdhm_mask_cell import bdhm_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     in_valid,
   output logic     in_ready,
   input  prod_type in_data,
   output logic     out_valid,
   input  logic     out_ready,
   output logic     out_data
);

   localparam logic [SAT_PROD_W-1:0] SatHalf = SAT_PROD_W'(1 << (HSV_SHIFT - 1));
   localparam logic signed [HUE_PROD_W-1:0] HueHalf = HUE_PROD_W'(1 << (HSV_SHIFT - 1));

   logic                         valid_ff;
   logic                         data_ff;
   logic                         data_in;
   logic [SAT_PROD_W-1:0]        sat_sum;
   logic signed [HUE_PROD_W-1:0] hue_sum;
   logic signed [HUE_RAW_W-1:0]  hue_raw;
   logic [HUE_RAW_W-1:0]         hue_wrap;
   logic [CHAN_W-1:0]            sat, hue;
   logic                         green, broad;

   always_comb begin
      sat_sum  = in_data.sat_prod + SatHalf;
      sat      = sat_sum[HSV_SHIFT +: CHAN_W];
      // Floor shift of the signed product keeps the rounding of negative hues.
      hue_sum  = in_data.hue_prod + HueHalf;
      hue_raw  = $signed(hue_sum[HSV_SHIFT +: HUE_RAW_W]);
      hue_wrap = hue_raw[HUE_RAW_W-1] ? HUE_RAW_W'(hue_raw) + HUE_RAW_W'(HUE_RANGE)
                                      : HUE_RAW_W'(hue_raw);
      hue      = hue_wrap[CHAN_W-1:0];
      green    = (hue >= cfg.green_hue_low) && (hue <= cfg.green_hue_high) &&
                 (sat >= cfg.green_sat_low) && (in_data.val >= cfg.green_val_low);
      broad    = (sat <= cfg.broad_sat_high) && (in_data.val >= cfg.broad_val_low);
      data_in  = green ^ broad;
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

[rtl/background_diff_hsv_mask_top.sv]
// Per-pixel foreground classifier on the difference of a frame and its background.
//
// A request on the req_ channel carries one current BGR pixel and the matching
// background pixel. The block converts the per-channel absolute difference to
// 8-bit HSV and answers on the rsp_ channel with one bit, rsp_foreground, which
// is the XOR of a green-band mask and a broad saturation/value mask.
//
// The work runs through a row of four cells (difference, reciprocal lookup,
// multiply, threshold), each with its own output register. A request passes
// through these registers in turn before its response is on rsp_, and one
// request is accepted in every cycle while the receiver keeps rsp_ready high.
//
// When the receiver stalls, the held response stays on rsp_ with its value
// unchanged, and the cells behind it keep filling until all four hold a
// request; only then does req_ready drop. Backpressure reaches req_ready in the
// same cycle through the ready chain of the cells.
//
// Reset empties all cells and loads the six threshold registers with their
// defaults. The csr_ port is always ready; indexes beyond the last register are
// ignored. Thresholds should only be rewritten while no request is in flight.
module background_diff_hsv_mask_top import bdhm_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [CHAN_W-1:0]      req_cur_blue,
   input  logic [CHAN_W-1:0]      req_cur_green,
   input  logic [CHAN_W-1:0]      req_cur_red,
   input  logic [CHAN_W-1:0]      req_bg_blue,
   input  logic [CHAN_W-1:0]      req_bg_green,
   input  logic [CHAN_W-1:0]      req_bg_red,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_foreground,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CHAN_W-1:0]      csr_data
);

   cfg_type   cfg_ff;
   cfg_type   cfg_in;
   pixel_type pixel;
   diff_type  diff_data;
   recip_type recip_data;
   prod_type  prod_data;
   logic      diff_valid, diff_ready;
   logic      recip_valid, recip_ready;
   logic      prod_valid, prod_ready;

   // Threshold registers. Writes complete in the cycle they are offered.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_GREEN_HUE_LOW:  cfg_in.green_hue_low  = csr_data;
            CSR_GREEN_HUE_HIGH: cfg_in.green_hue_high = csr_data;
            CSR_GREEN_SAT_LOW:  cfg_in.green_sat_low  = csr_data;
            CSR_GREEN_VAL_LOW:  cfg_in.green_val_low  = csr_data;
            CSR_BROAD_SAT_HIGH: cfg_in.broad_sat_high = csr_data;
            CSR_BROAD_VAL_LOW:  cfg_in.broad_val_low  = csr_data;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.green_hue_low  <= RST_GREEN_HUE_LOW;
         cfg_ff.green_hue_high <= RST_GREEN_HUE_HIGH;
         cfg_ff.green_sat_low  <= RST_GREEN_SAT_LOW;
         cfg_ff.green_val_low  <= RST_GREEN_VAL_LOW;
         cfg_ff.broad_sat_high <= RST_BROAD_SAT_HIGH;
         cfg_ff.broad_val_low  <= RST_BROAD_VAL_LOW;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      pixel.cur_blue  = req_cur_blue;
      pixel.cur_green = req_cur_green;
      pixel.cur_red   = req_cur_red;
      pixel.bg_blue   = req_bg_blue;
      pixel.bg_green  = req_bg_green;
      pixel.bg_red    = req_bg_red;
   end

   // Absolute differences, value, chroma spread and the hue numerator.
   bdhm_diff_cell u_diff (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (pixel),
      .out_valid (diff_valid),
      .out_ready (diff_ready),
      .out_data  (diff_data)
   );

   // Fixed-point reciprocals from two constant tables.
   bdhm_recip_cell u_recip (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (diff_valid),
      .in_ready  (diff_ready),
      .in_data   (diff_data),
      .out_valid (recip_valid),
      .out_ready (recip_ready),
      .out_data  (recip_data)
   );

   // Saturation and hue products.
   bdhm_mult_cell u_mult (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (recip_valid),
      .in_ready  (recip_ready),
      .in_data   (recip_data),
      .out_valid (prod_valid),
      .out_ready (prod_ready),
      .out_data  (prod_data)
   );

   // Rounding, hue wrap, the two masks and their XOR. Its register is the
   // response register seen on the rsp_ ports.
   bdhm_mask_cell u_mask (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (prod_valid),
      .in_ready  (prod_ready),
      .in_data   (prod_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_foreground)
   );

endmodule

[rtl/bdhm_checker.sv]
module bdhm_checker import bdhm_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic [CHAN_W-1:0]      req_cur_blue,
   input logic [CHAN_W-1:0]      req_cur_green,
   input logic [CHAN_W-1:0]      req_cur_red,
   input logic [CHAN_W-1:0]      req_bg_blue,
   input logic [CHAN_W-1:0]      req_bg_green,
   input logic [CHAN_W-1:0]      req_bg_red,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic                   rsp_foreground,
   input logic                   csr_valid,
   input logic                   csr_ready,
   input logic [CSR_INDEX_W-1:0] csr_index,
   input logic [CHAN_W-1:0]      csr_data
);

   // A stalled response holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_foreground))
      else $error("stalled response changed");

   // Reset empties the row of cells.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // A ready receiver lets every cell move, so a request is always taken.
   assert property (@(posedge clock) disable iff (reset) rsp_ready |-> req_ready)
      else $error("request refused while the receiver is ready");

   // Only a stalled response can block the request side.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request side blocked without output backpressure");

   // Register writes are never refused.
   assert property (@(posedge clock) disable iff (reset) csr_valid |-> csr_ready)
      else $error("register write refused");

endmodule

bind background_diff_hsv_mask_top bdhm_checker u_bdhm_checker (.*);
